// ===== sv/bed_pkg.sv =====
package bed_pkg;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_DIGIT    = 2'd1;
	localparam logic [1:0] ERR_RESERVED = 2'd2;

	localparam logic [31:0] UNI_LOW_MAX  = 32'h0000_009f;
	localparam logic [31:0] UNI_DOLLAR   = 32'h0000_0024;
	localparam logic [31:0] UNI_AT       = 32'h0000_0040;
	localparam logic [31:0] UNI_GRAVE    = 32'h0000_0060;
	localparam logic [31:0] UNI_SURR_LO  = 32'h0000_d800;
	localparam logic [31:0] UNI_SURR_HI  = 32'h0000_dfff;

	typedef struct packed {
		logic [31:0] code;
		logic [1:0]  err;
	} result_t;

	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} pair_t;

	typedef struct packed {
		logic  valid;
		pair_t pair;
	} qword_t;

	function automatic logic is_reserved(logic [31:0] v);
		is_reserved = (v <= UNI_LOW_MAX && v != UNI_DOLLAR && v != UNI_AT && v != UNI_GRAVE)
			|| (v >= UNI_SURR_LO && v <= UNI_SURR_HI);
	endfunction

endpackage

// ===== sv/bed_front.sv =====
module bed_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            cfg_data,
	input  logic            accept,
	input  logic [20:0]     char_code,
	input  logic            end_of_string,
	output bed_pkg::qword_t push
);

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_ESC  = 3'd1,
		MODE_HEX  = 3'd2,
		MODE_OCT  = 3'd3,
		MODE_U4   = 3'd4,
		MODE_U8   = 3'd5
	} mode_t;

	localparam logic [20:0] CH_BSL   = 21'h5c;
	localparam logic [20:0] CH_ZERO  = 21'h30;
	localparam logic [20:0] CH_SEVEN = 21'h37;
	localparam logic [20:0] CH_X     = 21'h78;
	localparam logic [20:0] CH_LU    = 21'h75;
	localparam logic [20:0] CH_UU    = 21'h55;
	localparam logic [20:0] CH_A     = 21'h61;
	localparam logic [20:0] CH_B     = 21'h62;
	localparam logic [20:0] CH_C     = 21'h63;
	localparam logic [20:0] CH_F     = 21'h66;
	localparam logic [20:0] CH_N     = 21'h6e;
	localparam logic [20:0] CH_R     = 21'h72;
	localparam logic [20:0] CH_T     = 21'h74;
	localparam logic [20:0] CH_V     = 21'h76;
	localparam logic [20:0] CH_QUOTE = 21'h22;

	logic  ozp_q;
	mode_t mode_q;
	logic [3:0]  cnt_q;
	logic [31:0] acc_q;
	logic        perr_q;

	mode_t       m1;
	logic [3:0]  c1;
	logic [31:0] a1;
	logic        p1;
	logic [3:0]  ev;
	bed_pkg::result_t er [4];
	logic        used;
	logic        hex_ok;
	logic [3:0]  hex_v;
	logic        oct_ok;
	logic [31:0] nv;
	logic [3:0]  nc;
	logic [3:0]  len;
	logic [3:0]  fill;
	logic [1:0]  n;
	bed_pkg::pair_t pr;

	// hex digit, either case
	always_comb begin
		hex_ok = 1'b0;
		hex_v  = char_code[3:0];
		if (char_code >= 21'h30 && char_code <= 21'h39) begin
			hex_ok = 1'b1;
		end else if ((char_code >= 21'h61 && char_code <= 21'h66)
				|| (char_code >= 21'h41 && char_code <= 21'h46)) begin
			hex_ok = 1'b1;
			hex_v  = char_code[3:0] + 4'd9;
		end
		oct_ok = char_code >= CH_ZERO && char_code <= CH_SEVEN;
	end

	always_comb begin
		m1   = MODE_IDLE;
		c1   = '0;
		a1   = '0;
		p1   = 1'b0;
		used = 1'b0;
		ev   = '0;
		for (int i = 0; i < 4; i++) begin
			er[i] = '0;
		end
		nv   = '0;
		nc   = '0;
		len  = '0;
		fill = '0;

		// slots 0 and 1: escape results, slot 2: plain char, slot 3: end of string flush
		case (mode_q)
			MODE_ESC: begin
				used = 1'b1;
				if (char_code == CH_X) begin
					m1 = MODE_HEX;
				end else if (oct_ok) begin
					m1 = MODE_OCT;
					if (!(ozp_q && char_code == CH_ZERO)) begin
						a1 = {29'd0, char_code[2:0]};
						c1 = 4'd1;
					end
				end else if (char_code == CH_LU) begin
					m1 = MODE_U4;
				end else if (char_code == CH_UU) begin
					m1 = MODE_U8;
				end else begin
					ev[0] = 1'b1;
					case (char_code)
						CH_A:     er[0].code = 32'd7;
						CH_B:     er[0].code = 32'd8;
						CH_C:     ev[0] = 1'b0;
						CH_F:     er[0].code = 32'd12;
						CH_N:     er[0].code = 32'd10;
						CH_R:     er[0].code = 32'd13;
						CH_T:     er[0].code = 32'd9;
						CH_V:     er[0].code = 32'd11;
						CH_QUOTE: er[0].code = {11'd0, CH_QUOTE};
						CH_BSL:   er[0].code = {11'd0, CH_BSL};
						default: begin
							er[0].code = {11'd0, CH_BSL};
							ev[1]      = 1'b1;
							er[1].code = {11'd0, char_code};
						end
					endcase
				end
			end
			MODE_HEX: begin
				if (hex_ok) begin
					used = 1'b1;
					nv   = {acc_q[27:0], hex_v};
					nc   = cnt_q + 4'd1;
					if (nc >= 4'd2) begin
						ev[0]      = 1'b1;
						er[0].code = nv;
					end else begin
						m1 = MODE_HEX;
						a1 = nv;
						c1 = nc;
					end
				end else begin
					ev[0]      = 1'b1;
					er[0].code = acc_q;
					er[0].err  = (cnt_q == 4'd0) ? bed_pkg::ERR_DIGIT : bed_pkg::ERR_NONE;
				end
			end
			MODE_OCT: begin
				if (oct_ok) begin
					used = 1'b1;
					nv   = {acc_q[28:0], char_code[2:0]};
					nc   = cnt_q + 4'd1;
					if (nc >= 4'd3) begin
						ev[0]      = 1'b1;
						er[0].code = {24'd0, nv[7:0]};
					end else begin
						m1 = MODE_OCT;
						a1 = nv;
						c1 = nc;
					end
				end else begin
					ev[0]      = 1'b1;
					er[0].code = {24'd0, acc_q[7:0]};
				end
			end
			MODE_U4, MODE_U8: begin
				used = 1'b1;
				len  = (mode_q == MODE_U4) ? 4'd4 : 4'd8;
				nv   = {acc_q[27:0], hex_ok ? hex_v : 4'd0};
				nc   = cnt_q + 4'd1;
				if (nc >= len) begin
					ev[0]      = 1'b1;
					er[0].code = nv;
					if (perr_q || !hex_ok) begin
						er[0].err = bed_pkg::ERR_DIGIT;
					end else if (bed_pkg::is_reserved(nv)) begin
						er[0].err = bed_pkg::ERR_RESERVED;
					end
				end else begin
					m1 = mode_q;
					a1 = nv;
					c1 = nc;
					p1 = perr_q || !hex_ok;
				end
			end
			default: begin
				m1 = MODE_IDLE;
			end
		endcase

		if (!used) begin
			if (char_code == CH_BSL) begin
				m1 = MODE_ESC;
			end else begin
				ev[2]      = 1'b1;
				er[2].code = {11'd0, char_code};
			end
		end

		if (end_of_string) begin
			case (m1)
				MODE_ESC: begin
					ev[3]      = 1'b1;
					er[3].code = {11'd0, CH_BSL};
				end
				MODE_HEX: begin
					ev[3]      = 1'b1;
					er[3].code = a1;
					er[3].err  = (c1 == 4'd0) ? bed_pkg::ERR_DIGIT : bed_pkg::ERR_NONE;
				end
				MODE_OCT: begin
					ev[3]      = 1'b1;
					er[3].code = {24'd0, a1[7:0]};
				end
				MODE_U4, MODE_U8: begin
					// missing digits count as zero
					fill       = ((m1 == MODE_U4) ? 4'd4 : 4'd8) - c1;
					ev[3]      = 1'b1;
					er[3].code = a1 << {fill, 2'b00};
					er[3].err  = bed_pkg::ERR_DIGIT;
				end
				default: begin
					ev[3] = 1'b0;
				end
			endcase
		end
	end

	// pack the first two results
	always_comb begin
		n  = '0;
		pr = '0;
		for (int i = 0; i < 4; i++) begin
			if (ev[i] && n == 2'd0) begin
				pr.r0 = er[i];
				n     = 2'd1;
			end else if (ev[i] && n == 2'd1) begin
				pr.r1  = er[i];
				pr.two = 1'b1;
				n      = 2'd2;
			end
		end
		push.valid = accept && n != 2'd0;
		push.pair  = pr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ozp_q  <= 1'b0;
			mode_q <= MODE_IDLE;
			cnt_q  <= '0;
			acc_q  <= '0;
			perr_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ozp_q <= cfg_data;
			end
			if (accept) begin
				if (end_of_string) begin
					mode_q <= MODE_IDLE;
					cnt_q  <= '0;
					acc_q  <= '0;
					perr_q <= 1'b0;
				end else begin
					mode_q <= m1;
					cnt_q  <= c1;
					acc_q  <= a1;
					perr_q <= p1;
				end
			end
		end
	end

endmodule

// ===== sv/bed_queue.sv =====
module bed_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bed_pkg::qword_t push,
	input  logic            pop,
	output logic            full,
	output bed_pkg::qword_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bed_pkg::pair_t mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full       = cnt_q == CW'(DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.pair  = mem_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/bed_back.sv =====
module bed_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bed_pkg::qword_t head,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [39:0]     m_tdata,  // out_code[31:0], error_code[33:32], zero pad
	output logic            m_tlast   // last_of_run
);

	logic             out_valid_q;
	bed_pkg::result_t out_q;
	logic             out_last_q;
	logic             pend_q;
	bed_pkg::result_t pend_r_q;
	logic             load;

	assign load     = !out_valid_q || m_tready;
	assign pop      = load && !pend_q && head.valid;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.err, out_q.code};
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q <= pend_r_q;
			end else begin
				out_q <= head.pair.r0;
			end
		end
		if (pop) begin
			pend_r_q <= head.pair.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				out_last_q  <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= head.valid;
				out_last_q  <= !head.pair.two;
				pend_q      <= head.valid && head.pair.two;
			end
		end
	end

endmodule

// ===== sv/backslash_escape_decoder.sv =====
// channel   dir  handshake          payload
// s_        in   tvalid / tready    tdata char_code, tlast end_of_string
// m_        out  tvalid / tready    tdata out_code + error_code, tlast last_of_run
// cfg_      in   valid / ready      data octal_zero_prefix
//
// one character is taken per cycle while the result queue has room
// a character yields zero, one or two results, sent one per cycle from the output register while m_tready is high
// an accepted character's results are written to the queue, then loaded into the output register
// asynchronous reset clears the decode state, empties the queue and invalidates the output register
// a stalled output fills the queue, then s_tready drops
module backslash_escape_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[20:0], zero pad
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_code[31:0], error_code[33:32], zero pad
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // octal_zero_prefix
);

	bed_pkg::qword_t push;
	bed_pkg::qword_t head;
	logic            full;
	logic            pop;
	logic            accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign accept    = s_tvalid && !full;

	bed_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.char_code     (s_tdata[20:0]),
		.end_of_string (s_tlast),
		.push          (push)
	);

	bed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	bed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== sv/bed_sva.sv =====
module bed_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'b11 && m_tdata[39:34] == 6'd0)
		else $error("bad error code or pad");

	a_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == bed_pkg::ERR_RESERVED |->
			((m_tdata[31:0] <= bed_pkg::UNI_LOW_MAX && m_tdata[31:0] != bed_pkg::UNI_DOLLAR
			&& m_tdata[31:0] != bed_pkg::UNI_AT && m_tdata[31:0] != bed_pkg::UNI_GRAVE)
			|| (m_tdata[31:0] >= bed_pkg::UNI_SURR_LO && m_tdata[31:0] <= bed_pkg::UNI_SURR_HI)))
		else $error("reserved flag on a valid code point");

endmodule

bind backslash_escape_decoder bed_sva u_bed_sva (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/decode_checker.sv =====
`timescale 1ns / 100ps

module decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          mismatches,
	output int          outstanding
);

	localparam logic [20:0] CH_BSL = 21'h00005c;

	typedef enum logic [2:0] {DM_IDLE, DM_ESC, DM_HEX, DM_OCT, DM_U4, DM_U8} dmode_t;

	typedef struct packed {
		logic [31:0] code;
		logic [1:0]  err;
		logic        last;
	} outchar_t;

	dmode_t      mode;
	logic [3:0]  ndig;
	logic [31:0] acc;
	logic        bad_digit;
	logic        zero_prefix;

	outchar_t    step_res [2];
	int          nres;
	outchar_t    want_q [$];

	function automatic int nibble_of(logic [20:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	task automatic put(logic [31:0] code, logic [1:0] err);
		if (nres < 2) begin
			step_res[nres] = '{code: code, err: err, last: 1'b0};
			nres++;
		end
	endtask

	task automatic to_idle();
		mode = DM_IDLE;
		ndig = '0;
		acc = '0;
		bad_digit = 1'b0;
	endtask

	task automatic close_uni();
		logic [1:0] e;
		if (bad_digit) begin
			e = bed_pkg::ERR_DIGIT;
		end else if ((acc <= bed_pkg::UNI_LOW_MAX && acc != bed_pkg::UNI_DOLLAR
				&& acc != bed_pkg::UNI_AT && acc != bed_pkg::UNI_GRAVE)
				|| (acc >= bed_pkg::UNI_SURR_LO && acc <= bed_pkg::UNI_SURR_HI)) begin
			e = bed_pkg::ERR_RESERVED;
		end else begin
			e = bed_pkg::ERR_NONE;
		end
		put(acc, e);
		to_idle();
	endtask

	// emit whatever escape is still open
	task automatic flush_open();
		case (mode)
			DM_ESC: put({11'b0, CH_BSL}, bed_pkg::ERR_NONE);
			DM_HEX: put(acc, (ndig == 0) ? bed_pkg::ERR_DIGIT : bed_pkg::ERR_NONE);
			DM_OCT: put({24'b0, acc[7:0]}, bed_pkg::ERR_NONE);
			DM_U4, DM_U8: begin
				while (ndig < ((mode == DM_U4) ? 4 : 8)) begin
					acc = acc << 4;
					ndig++;
					bad_digit = 1'b1;
				end
				close_uni();
			end
			default: ;
		endcase
		to_idle();
	endtask

	task automatic after_bsl(logic [20:0] c);
		to_idle();
		if (c == "x") begin
			mode = DM_HEX;
		end else if (c >= "0" && c <= "7") begin
			mode = DM_OCT;
			if (!(zero_prefix && c == "0")) begin
				acc = 32'(c - "0");
				ndig = 4'd1;
			end
		end else if (c == "u") begin
			mode = DM_U4;
		end else if (c == "U") begin
			mode = DM_U8;
		end else begin
			case (c)
				"a": put(32'd7, bed_pkg::ERR_NONE);
				"b": put(32'd8, bed_pkg::ERR_NONE);
				"c": ;
				"f": put(32'd12, bed_pkg::ERR_NONE);
				"n": put(32'd10, bed_pkg::ERR_NONE);
				"r": put(32'd13, bed_pkg::ERR_NONE);
				"t": put(32'd9, bed_pkg::ERR_NONE);
				"v": put(32'd11, bed_pkg::ERR_NONE);
				"\"": put(32'h22, bed_pkg::ERR_NONE);
				CH_BSL: put({11'b0, CH_BSL}, bed_pkg::ERR_NONE);
				default: begin
					put({11'b0, CH_BSL}, bed_pkg::ERR_NONE);
					put({11'b0, c}, bed_pkg::ERR_NONE);
				end
			endcase
		end
	endtask

	task automatic decode_char(logic [20:0] c, logic eos);
		int   hv;
		logic used;
		used = 1'b0;
		nres = 0;
		case (mode)
			DM_ESC: begin
				after_bsl(c);
				used = 1'b1;
			end
			DM_HEX: begin
				hv = nibble_of(c);
				if (hv >= 0) begin
					acc = acc * 16 + hv;
					ndig++;
					used = 1'b1;
					if (ndig >= 2) begin
						put(acc, bed_pkg::ERR_NONE);
						to_idle();
					end
				end else begin
					flush_open();
				end
			end
			DM_OCT: begin
				if (c >= "0" && c <= "7") begin
					acc = acc * 8 + (c - "0");
					ndig++;
					used = 1'b1;
					if (ndig >= 3) begin
						put({24'b0, acc[7:0]}, bed_pkg::ERR_NONE);
						to_idle();
					end
				end else begin
					flush_open();
				end
			end
			DM_U4, DM_U8: begin
				hv = nibble_of(c);
				if (hv < 0) begin
					hv = 0;
					bad_digit = 1'b1;
				end
				acc = (acc << 4) | hv;
				ndig++;
				used = 1'b1;
				if (ndig >= ((mode == DM_U4) ? 4 : 8)) close_uni();
			end
			default: to_idle();
		endcase
		if (!used) begin
			if (c == CH_BSL) mode = DM_ESC;
			else put({11'b0, c}, bed_pkg::ERR_NONE);
		end
		if (eos) flush_open();
		if (nres > 0) step_res[nres - 1].last = 1'b1;
		for (int i = 0; i < nres; i++) want_q.push_back(step_res[i]);
	endtask

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
	endtask

	task automatic check_result();
		outchar_t w;
		if (want_q.size() == 0) begin
			flag_mismatch("unexpected result", m_tdata[31:0], '0);
			return;
		end
		w = want_q.pop_front();
		if (m_tdata[31:0] != w.code) flag_mismatch("out_code", m_tdata[31:0], w.code);
		if (m_tdata[33:32] != w.err)
			flag_mismatch("error_code", 32'(m_tdata[33:32]), 32'(w.err));
		if (m_tlast != w.last) flag_mismatch("last_of_run", 32'(m_tlast), 32'(w.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_idle();
			zero_prefix = 1'b0;
			want_q.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			// a result at this edge never comes from the character taken at this edge
			if (m_tvalid && m_tready) check_result();
			if (cfg_valid && cfg_ready) zero_prefix = cfg_data;
			if (s_tvalid && s_tready) decode_char(s_tdata[20:0], s_tlast);
			outstanding = want_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int WATCH_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_CHARS = 270;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [20:0] CH_BSL = 21'h00005c;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	int   mismatches;
	int   outstanding;
	int   quiet = 0;
	int   sent;
	logic src_idle = 1'b1;
	logic sink_idle = 1'b1;
	logic hold_req = 1'b0;

	always #5 clk = ~clk;

	backslash_escape_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	decode_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= WATCH_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_char(logic [20:0] c, logic eos);
		@(negedge clk);
		if (src_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b0, c};
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_text(string t, logic eos_at_end);
		for (int i = 0; i < t.len(); i++)
			send_char(21'(t[i]), eos_at_end && i == t.len() - 1);
	endtask

	// drain every expected result, then give the block time to finish silent work
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [20:0] hex_ch(logic [3:0] n);
		if (n < 10) return 21'("0" + n);
		return 21'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
	endfunction

	function automatic logic [20:0] uni_digit(logic [3:0] n);
		if ($urandom_range(0, 11) == 0) return 21'("g" + $urandom_range(0, 19));
		return hex_ch(n);
	endfunction

	function automatic logic [20:0] any_char();
		logic [20:0] c;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			c = 21'($urandom_range(32, 126));
			if (c == CH_BSL) c = 21'("a");
		end else if (r < 85) begin
			c = 21'($urandom);
		end else begin
			case ($urandom_range(0, 4))
				0: c = 21'h000000;
				1: c = 21'h10ffff;
				2: c = 21'h110000;
				3: c = 21'h1fffff;
				default: c = 21'($urandom_range(0, 16'hffff));
			endcase
		end
		return c;
	endfunction

	function automatic logic [20:0] esc_letter();
		string letters;
		letters = "abcfnrtv\"\\";
		if ($urandom_range(0, 4) == 0) return any_char();
		return 21'(letters[$urandom_range(0, letters.len() - 1)]);
	endfunction

	function automatic logic [31:0] rand_code_point(logic wide);
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 8'hff);
			1: v = $urandom_range(16'hd7f0, 16'he010);
			2: begin
				case ($urandom_range(0, 4))
					0: v = bed_pkg::UNI_DOLLAR;
					1: v = bed_pkg::UNI_AT;
					2: v = bed_pkg::UNI_GRAVE;
					3: v = bed_pkg::UNI_LOW_MAX;
					default: v = bed_pkg::UNI_LOW_MAX + 1;
				endcase
			end
			3: v = wide ? $urandom_range(21'h10fff0, 21'h110010) : $urandom_range(0, 16'hffff);
			default: v = wide ? $urandom : $urandom_range(0, 16'hffff);
		endcase
		return v;
	endfunction

	// one plain character or one escape sequence, now and then cut or broken
	task automatic send_token();
		logic [20:0] tok [$];
		logic [31:0] v;
		int          sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			tok.push_back(any_char());
		end else begin
			tok.push_back(CH_BSL);
			if (sel < 55) begin
				tok.push_back(esc_letter());
			end else if (sel < 65) begin
				tok.push_back(21'("x"));
				repeat ($urandom_range(0, 3)) tok.push_back(hex_ch($urandom_range(0, 15)));
			end else if (sel < 78) begin
				tok.push_back(21'(($urandom_range(0, 3) == 0) ? "0" : "0" + $urandom_range(0, 7)));
				repeat ($urandom_range(0, 3)) tok.push_back(21'("0" + $urandom_range(0, 7)));
			end else if (sel < 91) begin
				tok.push_back(21'("u"));
				v = rand_code_point(1'b0);
				for (int k = 3; k >= 0; k--) tok.push_back(uni_digit(v[k*4 +: 4]));
			end else begin
				tok.push_back(21'("U"));
				v = rand_code_point(1'b1);
				for (int k = 7; k >= 0; k--) tok.push_back(uni_digit(v[k*4 +: 4]));
			end
			if ($urandom_range(0, 9) == 0) tok = tok[0:$urandom_range(0, tok.size() - 1)];
		end
		foreach (tok[i]) begin
			send_char(tok[i], $urandom_range(0, 19) == 0);
			sent++;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_cfg(1'b0);

		send_text("A", 1'b0);
		send_char(21'h000000, 1'b0);
		send_char(21'h1fffff, 1'b1);
		send_text("\\n", 1'b0);
		send_text("\\q", 1'b0);
		send_text("\\xAf", 1'b0);
		send_text("\\xG", 1'b0);
		send_text("\\777", 1'b0);
		send_text("\\u0041", 1'b0);
		send_text("\\", 1'b1);

		for (int p = 0; p < 4; p++) begin
			write_cfg(p % 2 == 0);
			src_idle = (p < 3);
			sink_idle = (p < 3);
			if (p == 1) hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_CHARS) send_token();
			// close any open escape before the next register write
			send_char(21'("Z"), 1'b1);
		end

		settle();
		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
